@@ sv/rme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types, constants and the arctangent table of the Euler angle unit.
// ----------------------------------------------------------------------------
package rme_pkg;

	localparam int CordicStages = 16;
	localparam int IterCount = (CordicStages < 24) ? CordicStages : 24;
	localparam int SqrtSteps = 16;
	localparam int AccW = 36;
	localparam int ZW = 34;
	localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;

	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r10;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
	} mat_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic               is_singular;
	} ang_t;

	typedef struct packed {
		logic signed [AccW-1:0] x;
		logic signed [AccW-1:0] y;
		logic signed [ZW-1:0]   z;
		logic                   zero;
	} cvec_t;

	function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		begin
			unique case (i)
				5'd0: r = 34'sh3243F6A8;
				5'd1: r = 34'sh1DAC6705;
				5'd2: r = 34'sh0FADBAFC;
				5'd3: r = 34'sh07F56EA6;
				5'd4: r = 34'sh03FEAB76;
				5'd5: r = 34'sh01FFD55B;
				5'd6: r = 34'sh00FFFAAA;
				5'd7: r = 34'sh007FFF55;
				5'd8: r = 34'sh003FFFEA;
				5'd9: r = 34'sh001FFFFD;
				5'd10: r = 34'sh000FFFFF;
				5'd11: r = 34'sh0007FFFF;
				5'd12: r = 34'sh0003FFFF;
				5'd13: r = 34'sh0001FFFF;
				5'd14: r = 34'sh0000FFFF;
				5'd15: r = 34'sh00007FFF;
				5'd16: r = 34'sh00003FFF;
				5'd17: r = 34'sh00001FFF;
				5'd18: r = 34'sh00000FFF;
				5'd19: r = 34'sh000007FF;
				5'd20: r = 34'sh000003FF;
				5'd21: r = 34'sh000001FF;
				5'd22: r = 34'sh000000FF;
				5'd23: r = 34'sh0000007F;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

@@ sv/rme_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_if
// Valid/ready channel interfaces for matrices, angles and configuration.
// ----------------------------------------------------------------------------
interface rme_mat_if;
	logic           valid;
	logic           ready;
	rme_pkg::mat_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rme_ang_if;
	logic           valid;
	logic           ready;
	rme_pkg::ang_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rme_cfg_if;
	logic        valid;
	logic        ready;
	logic [14:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/rme_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_sqrt_cell
// One restoring square root step: one result bit per cell.
// ----------------------------------------------------------------------------
module rme_sqrt_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [33:0] rem_in,
	input  logic [16:0] root_in,
	input  logic [31:0] rad_in,
	output logic [33:0] rem_out,
	output logic [16:0] root_out,
	output logic [31:0] rad_out
);
	logic [33:0] rem_sh;
	logic [33:0] trial;
	logic [33:0] rem_nx;
	logic [16:0] root_nx;

	always_comb begin
		rem_sh = {rem_in[31:0], rad_in[31:30]};
		trial = {15'd0, root_in, 2'b01};
		if (rem_sh >= trial) begin
			rem_nx = rem_sh - trial;
			root_nx = {root_in[15:0], 1'b1};
		end else begin
			rem_nx = rem_sh;
			root_nx = {root_in[15:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= rem_nx;
			root_out <= root_nx;
			rad_out <= {rad_in[29:0], 2'b00};
		end
	end
endmodule

@@ sv/rme_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_cordic_cell
// One vectoring CORDIC micro-rotation with its fixed shift and table angle.
// ----------------------------------------------------------------------------
module rme_cordic_cell (
	input  logic                clk,
	input  logic                en,
	input  logic [4:0]          step,
	input  rme_pkg::cvec_t      vin,
	output rme_pkg::cvec_t      vout
);
	rme_pkg::cvec_t vnx;
	logic signed [rme_pkg::AccW-1:0] xs;
	logic signed [rme_pkg::AccW-1:0] ys;

	always_comb begin
		xs = vin.x >>> step;
		ys = vin.y >>> step;
		vnx = vin;
		if (!vin.y[rme_pkg::AccW-1]) begin
			vnx.x = vin.x + ys;
			vnx.y = vin.y - xs;
			vnx.z = vin.z + rme_pkg::atan_tab(step);
		end else begin
			vnx.x = vin.x - ys;
			vnx.y = vin.y + xs;
			vnx.z = vin.z - rme_pkg::atan_tab(step);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vout <= vnx;
		end
	end
endmodule

@@ sv/rme_atan2.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_atan2
// Pre-rotation register followed by a row of CORDIC cells; result in Q3.13.
// ----------------------------------------------------------------------------
module rme_atan2 (
	input  logic                clk,
	input  logic                en,
	input  logic signed [17:0]  y,
	input  logic signed [17:0]  x,
	output logic signed [15:0]  ang
);
	rme_pkg::cvec_t pre;
	rme_pkg::cvec_t chain [rme_pkg::IterCount+1];
	logic signed [rme_pkg::ZW-1:0] zr;

	always_comb begin
		pre.zero = (x == 18'sd0) && (y == 18'sd0);
		pre.x = {{(rme_pkg::AccW-34){x[17]}}, x, 16'd0};
		pre.y = {{(rme_pkg::AccW-34){y[17]}}, y, 16'd0};
		pre.z = '0;
		if (x[17]) begin
			pre.x = -pre.x;
			pre.y = -pre.y;
			pre.z = y[17] ? -rme_pkg::PiQ30 : rme_pkg::PiQ30;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chain[0] <= pre;
		end
	end

	for (genvar g = 0; g < rme_pkg::IterCount; g++) begin : g_cell
		rme_cordic_cell u_cell (
			.clk  (clk),
			.en   (en),
			.step (5'(g)),
			.vin  (chain[g]),
			.vout (chain[g+1])
		);
	end

	assign zr = chain[rme_pkg::IterCount].z + 34'sd65536;
	assign ang = chain[rme_pkg::IterCount].zero ? 16'sd0 : 16'(zr >>> 17);
endmodule

@@ sv/rotation_matrix_to_euler_angles_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_unit
// Z-Y-X Euler angles from a Q2.14 rotation matrix, fully pipelined.
// ----------------------------------------------------------------------------
// One matrix is accepted every cycle. Each passes an input register, 16
// square root cells, a pre-rotation register, CORDIC cells (16 by default)
// and an output register. The whole pipeline advances only when its output
// register is free or being emptied, so a stalled result holds all items.
module rotation_matrix_to_euler_angles_unit (
	input logic         clk,
	input logic         arst_n,
	rme_mat_if.sink     mat,
	rme_ang_if.source   ang,
	rme_cfg_if.sink     cfg
);
	localparam int Lat1 = rme_pkg::SqrtSteps + 1;
	localparam int Lat = Lat1 + rme_pkg::IterCount + 1;

	logic [14:0] thr_q;
	logic        en;
	logic [Lat-1:0] vld_q;
	logic        out_vld_q;

	rme_pkg::mat_t mat_s1;
	logic [33:0] rem [rme_pkg::SqrtSteps+1];
	logic [16:0] root [rme_pkg::SqrtSteps+1];
	logic [31:0] rad [rme_pkg::SqrtSteps+1];
	rme_pkg::mat_t mdl [rme_pkg::SqrtSteps+1];

	logic singular;
	logic signed [17:0] ay_r, ax_r, ay_p, ax_p, ay_y, ax_y;
	logic signed [15:0] roll_c, pitch_c, yaw_c;
	logic sing_d [rme_pkg::IterCount+1];
	rme_pkg::ang_t out_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd1;
		end else if (cfg.valid) begin
			thr_q <= cfg.data;
		end
	end

	assign en = !out_vld_q || ang.ready;
	assign mat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], mat.valid};
			out_vld_q <= vld_q[Lat-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s1 <= mat.data;
		end
	end

	assign rem[0] = '0;
	assign root[0] = '0;
	assign rad[0] = 32'(32'(mat_s1.r00) * 32'(mat_s1.r00))
		+ 32'(32'(mat_s1.r10) * 32'(mat_s1.r10));
	assign mdl[0] = mat_s1;

	for (genvar g = 0; g < rme_pkg::SqrtSteps; g++) begin : g_sqrt
		rme_sqrt_cell u_sq (
			.clk      (clk),
			.en       (en),
			.rem_in   (rem[g]),
			.root_in  (root[g]),
			.rad_in   (rad[g]),
			.rem_out  (rem[g+1]),
			.root_out (root[g+1]),
			.rad_out  (rad[g+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				mdl[g+1] <= mdl[g];
			end
		end
	end

	always_comb begin
		singular = {2'b00, thr_q} > root[rme_pkg::SqrtSteps];
		ay_p = -18'(mdl[rme_pkg::SqrtSteps].r20);
		ax_p = 18'(signed'({1'b0, root[rme_pkg::SqrtSteps]}));
		ay_y = 18'(mdl[rme_pkg::SqrtSteps].r10);
		ax_y = 18'(mdl[rme_pkg::SqrtSteps].r00);
		if (singular) begin
			ay_r = -18'(mdl[rme_pkg::SqrtSteps].r12);
			ax_r = 18'(mdl[rme_pkg::SqrtSteps].r11);
		end else begin
			ay_r = 18'(mdl[rme_pkg::SqrtSteps].r21);
			ax_r = 18'(mdl[rme_pkg::SqrtSteps].r22);
		end
	end

	rme_atan2 u_roll (.clk(clk), .en(en), .y(ay_r), .x(ax_r), .ang(roll_c));
	rme_atan2 u_pitch (.clk(clk), .en(en), .y(ay_p), .x(ax_p), .ang(pitch_c));
	rme_atan2 u_yaw (.clk(clk), .en(en), .y(ay_y), .x(ax_y), .ang(yaw_c));

	assign sing_d[0] = singular;
	for (genvar g = 0; g < rme_pkg::IterCount; g++) begin : g_flag
		always_ff @(posedge clk) begin
			if (en) begin
				sing_d[g+1] <= sing_d[g];
			end
		end
	end

	logic sing_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sing_s2 <= sing_d[rme_pkg::IterCount];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.roll <= roll_c;
			out_q.pitch <= pitch_c;
			out_q.yaw <= sing_s2 ? 16'sd0 : yaw_c;
			out_q.is_singular <= sing_s2;
		end
	end

	assign ang.valid = out_vld_q;
	assign ang.data = out_q;
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives matrices into the Euler angle unit under random source gaps and
// sink stalls, predicts each angle set with a bit-exact CORDIC model and
// checks every result in order. The singular threshold is changed between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;

	localparam int Latency = 40;
	localparam int WatchdogLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rme_mat_if mat ();
	rme_ang_if ang ();
	rme_cfg_if cfg ();

	rotation_matrix_to_euler_angles_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.mat(mat.sink),
		.ang(ang.source),
		.cfg(cfg.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rme_pkg::mat_t pending_mats[$];
	rme_pkg::ang_t expected_angles[$];
	logic [14:0] threshold;
	int errors = 0;
	int idle_cycles = 0;
	int mat_gap = 0;
	int ang_stall = 0;
	bit cfg_req = 1'b0;
	logic [14:0] cfg_value = '0;
	bit cfg_done = 1'b0;

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [15:0] cordic_atan2(longint y, longint x);
		longint z;
		longint xs;
		longint ys;
		longint tab;
		z = 0;
		if (x == 0 && y == 0) return '0;
		if (x < 0) begin
			z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
			x = -x;
			y = -y;
		end
		x = x * 65536;
		y = y * 65536;
		for (int i = 0; i < rme_pkg::IterCount; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			tab = longint'(rme_pkg::atan_tab(5'(i)));
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += tab;
			end else begin
				x -= ys;
				y += xs;
				z -= tab;
			end
		end
		return 16'(shr_floor(z + 65536, 17));
	endfunction

	function automatic rme_pkg::ang_t euler_angles(rme_pkg::mat_t m, logic [14:0] thr);
		rme_pkg::ang_t a;
		longint sum;
		longint sy;
		sum = longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10;
		sy = 0;
		while ((sy + 1) * (sy + 1) <= sum) sy++;
		a.is_singular = (sy < longint'(thr));
		a.pitch = cordic_atan2(-longint'(m.r20), sy);
		if (!a.is_singular) begin
			a.roll = cordic_atan2(m.r21, m.r22);
			a.yaw = cordic_atan2(m.r10, m.r00);
		end else begin
			a.roll = cordic_atan2(-longint'(m.r12), m.r11);
			a.yaw = '0;
		end
		return a;
	endfunction

	function automatic logic signed [15:0] rand_entry();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0) return 16'(-16384);
		if (k == 1) return 16'sd16384;
		if (k == 2) return 16'($urandom);
		if (k < 6) return 16'(int'($urandom_range(0, 512)) - 256);
		return 16'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic int rand_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Driver: matrices come from the pending queue, each with a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat.valid <= 1'b0;
			mat.data <= '0;
			mat_gap <= 0;
		end else if (mat.valid && !mat.ready) begin
		end else if (mat_gap > 0) begin
			mat.valid <= 1'b0;
			mat_gap <= mat_gap - 1;
		end else if (pending_mats.size() > 0) begin
			mat.valid <= 1'b1;
			mat.data <= pending_mats[0];
			expected_angles.push_back(euler_angles(pending_mats[0], threshold));
			void'(pending_mats.pop_front());
			mat_gap <= rand_gap();
		end else begin
			mat.valid <= 1'b0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.valid <= 1'b0;
			cfg.data <= '0;
			cfg_done <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			cfg.valid <= 1'b0;
			cfg_done <= 1'b1;
		end else if (cfg_req && !cfg_done && !cfg.valid) begin
			cfg.valid <= 1'b1;
			cfg.data <= cfg_value;
		end else if (!cfg_req) begin
			cfg_done <= 1'b0;
		end
	end

	// Monitor: compares each angle transaction with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		rme_pkg::ang_t want;
		if (!arst_n) begin
			ang.ready <= 1'b0;
			ang_stall <= 0;
			idle_cycles <= 0;
		end else begin
			if ((mat.valid && mat.ready) || (ang.valid && ang.ready)
					|| (cfg.valid && cfg.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (ang.valid && ang.ready) begin
				if (expected_angles.size() == 0) begin
					$display("%0t: unexpected result %h", $time, ang.data);
					errors++;
				end else begin
					want = expected_angles.pop_front();
					if (ang.data.roll !== want.roll)
						$display("%0t: roll expected %0d actual %0d",
							$time, want.roll, ang.data.roll);
					if (ang.data.pitch !== want.pitch)
						$display("%0t: pitch expected %0d actual %0d",
							$time, want.pitch, ang.data.pitch);
					if (ang.data.yaw !== want.yaw)
						$display("%0t: yaw expected %0d actual %0d",
							$time, want.yaw, ang.data.yaw);
					if (ang.data.is_singular !== want.is_singular)
						$display("%0t: is_singular expected %0b actual %0b",
							$time, want.is_singular, ang.data.is_singular);
					if (ang.data !== want)
						errors++;
				end
			end
			if (ang_stall > 0) begin
				ang.ready <= 1'b0;
				ang_stall <= ang_stall - 1;
			end else begin
				ang.ready <= 1'b1;
				ang_stall <= ($urandom_range(0, 3) == 0) ? rand_gap() : 0;
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WatchdogLimit) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic add_mat(int a, int b, int c, int d, int e, int f, int g);
		rme_pkg::mat_t m;
		m.r00 = 16'(a);
		m.r10 = 16'(b);
		m.r20 = 16'(c);
		m.r21 = 16'(d);
		m.r22 = 16'(e);
		m.r11 = 16'(f);
		m.r12 = 16'(g);
		pending_mats.push_back(m);
	endtask

	task automatic drain();
		while (pending_mats.size() > 0 || expected_angles.size() > 0 || mat.valid)
			@(posedge clk);
		repeat (Latency) @(posedge clk);
	endtask

	task automatic set_threshold(logic [14:0] v);
		cfg_value = v;
		cfg_req = 1'b1;
		while (!cfg_done) @(posedge clk);
		threshold = v;
		cfg_req = 1'b0;
		@(posedge clk);
	endtask

	task automatic add_random(int n);
		rme_pkg::mat_t m;
		for (int i = 0; i < n; i++) begin
			m.r00 = rand_entry();
			m.r10 = rand_entry();
			m.r20 = rand_entry();
			m.r21 = rand_entry();
			m.r22 = rand_entry();
			m.r11 = rand_entry();
			m.r12 = rand_entry();
			if ($urandom_range(0, 7) == 0) begin
				m.r00 = 16'(int'($urandom_range(0, 64)) - 32);
				m.r10 = 16'(int'($urandom_range(0, 64)) - 32);
			end
			pending_mats.push_back(m);
		end
	endtask

	initial begin
		logic [14:0] thresholds[6];
		threshold = 15'd1;
		thresholds = '{15'd0, 15'd16384, 15'h7FFF, 15'd40, 15'd1000, 15'd1};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		add_mat(16384, 0, 0, 0, 16384, 16384, 0);
		add_mat(0, 0, 0, 0, 0, 0, 0);
		add_mat(0, 0, -16384, 16384, 0, 16384, 0);
		add_mat(0, 0, 16384, 0, -16384, -16384, 16384);
		add_mat(-16384, 0, 0, 0, -16384, 0, -16384);
		add_mat(-16384, -1, 1, -1, -16384, -16384, 0);
		add_mat(-16384, 1, -1, 1, -16384, 0, 0);
		add_mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
		add_mat(32767, 32767, 32767, 32767, 32767, 32767, 32767);
		add_mat(11585, 11585, -16384, 16384, 16384, 16384, 16384);
		add_mat(0, 16384, 0, -16384, 0, 1, -1);
		add_mat(-1, 0, 0, 0, -1, -1, 1);
		drain();
		for (int p = 0; p < 6; p++) begin
			set_threshold(thresholds[p]);
			add_mat(0, 0, 5, 7, -9, 3, -4);
			add_mat(int'(thresholds[p]), 0, 0, 1, 1, 1, 1);
			add_random(190);
			drain();
		end
		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/rme_pkg.sv
sv/rme_if.sv
sv/rme_sqrt_cell.sv
sv/rme_cordic_cell.sv
sv/rme_atan2.sv
sv/rotation_matrix_to_euler_angles_unit.sv
sim/testbench.sv
